/* hdl/bqd_pkg.sv */
// Shared constants, payload types and the microcode store for the biquad section.
// Used by biquad_lowpass_df2t; has no dependencies of its own.
package bqd_pkg;

    // Sizing
    localparam int CHANNELS       = 4;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;
    localparam int CHAN_W         = 2;
    localparam int COEF_W         = 32;
    localparam int NUM_COEF       = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int DLY_FRAC       = 12;
    localparam int DLY_W          = 48;
    localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Datapath widths (multiplier B operand carries x, y high part or y low part)
    localparam int MUL_B_W    = SAMPLE_BITS;
    localparam int PROD_W     = COEF_W + MUL_B_W;
    localparam int PROD_SHIFT = COEF_FRAC_BITS - DLY_FRAC;
    localparam int TERM_W     = PROD_W - PROD_SHIFT;
    localparam int YACC_W     = DLY_W + 1;
    localparam int RSUM_W     = YACC_W + 1;
    localparam int RND_W      = RSUM_W - DLY_FRAC;
    localparam int YFB_W      = SAMPLE_BITS + DLY_FRAC;
    localparam int MIX_W      = PROD_W + 1;
    localparam int MY_W       = MIX_W - PROD_SHIFT;
    localparam int ACC_W      = DLY_W + 2;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [YFB_W-1:0] YFB_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}, {DLY_FRAC{1'b0}}};
    localparam logic signed [YFB_W-1:0] YFB_MIN = {1'b1, {(YFB_W-1){1'b0}}};
    localparam logic signed [DLY_W-1:0] DLY_MAX = {1'b0, {(DLY_W-1){1'b1}}};
    localparam logic signed [DLY_W-1:0] DLY_MIN = {1'b1, {(DLY_W-1){1'b0}}};
    localparam logic signed [RSUM_W-1:0] RND_HALF = RSUM_W'(2 ** (DLY_FRAC - 1));
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(2 ** COEF_FRAC_BITS);

    // Coefficient register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

    // Multiplier B operand select
    localparam logic [1:0] MB_X  = 2'd0;
    localparam logic [1:0] MB_YH = 2'd1;
    localparam logic [1:0] MB_YL = 2'd2;

    // Accumulator operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_YACC = 3'd1;
    localparam logic [2:0] OP_D1X  = 3'd2;
    localparam logic [2:0] OP_D2X  = 3'd3;
    localparam logic [2:0] OP_MIX  = 3'd4;
    localparam logic [2:0] OP_SUB1 = 3'd5;
    localparam logic [2:0] OP_SUB2 = 3'd6;

    // Branch conditions
    localparam logic [2:0] C_NEVER    = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_NO_INPUT = 3'd2;
    localparam logic [2:0] C_SKIP     = 3'd3;
    localparam logic [2:0] C_OUT_BUSY = 3'd4;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_WRITE = STEP_W'(10);

    typedef struct packed {
        logic [CHAN_W-1:0]             channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          clear_state;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]             channel_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] mul_a;
        logic [1:0]           mul_b;
        logic [2:0]           alu;
        logic [2:0]           cond;
        logic [STEP_W-1:0]    target;
        logic                 done;
    } t_uop;

    function automatic t_uop mk_uop(input logic [CFG_IDX_W-1:0] a, input logic [1:0] b,
                                    input logic [2:0] alu, input logic [2:0] cond,
                                    input logic [STEP_W-1:0] target, input logic done);
        t_uop u;
        u.mul_a  = a;
        u.mul_b  = b;
        u.alu    = alu;
        u.cond   = cond;
        u.target = target;
        u.done   = done;
        return u;
    endfunction

    // Program: a product is consumed in the next step; OP_MIX also uses the one before.
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            STEP_W'(0):  u = mk_uop(REG_B0, MB_X,  OP_NONE, C_NO_INPUT, STEP_IDLE,  1'b0);
            STEP_W'(1):  u = mk_uop(REG_B0, MB_X,  OP_NONE, C_SKIP,     STEP_WRITE, 1'b0);
            STEP_W'(2):  u = mk_uop(REG_B1, MB_X,  OP_YACC, C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(3):  u = mk_uop(REG_B2, MB_X,  OP_D1X,  C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(4):  u = mk_uop(REG_A1, MB_YH, OP_D2X,  C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(5):  u = mk_uop(REG_A1, MB_YL, OP_NONE, C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(6):  u = mk_uop(REG_A2, MB_YH, OP_MIX,  C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(7):  u = mk_uop(REG_A2, MB_YL, OP_SUB1, C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(8):  u = mk_uop(REG_A2, MB_YL, OP_MIX,  C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(9):  u = mk_uop(REG_A2, MB_YL, OP_SUB2, C_NEVER,    STEP_IDLE,  1'b0);
            STEP_W'(10): u = mk_uop(REG_B0, MB_X,  OP_NONE, C_OUT_BUSY, STEP_WRITE, 1'b1);
            default:     u = mk_uop(REG_B0, MB_X,  OP_NONE, C_ALWAYS,   STEP_IDLE,  1'b0);
        endcase
        return u;
    endfunction

endpackage

/* hdl/biquad_lowpass_df2t.sv */
// Multichannel biquad section (transposed direct form II), microcoded datapath.
// Depends on bqd_pkg for payload types, widths and the microcode store.
//
// Channel   Ports                                     Transfer when
// input     i_in_valid, o_in_stall, i_in_data         i_in_valid & !o_in_stall
// output    o_out_valid, i_out_stall, o_out_data      o_out_valid & !i_out_stall
// config    i_cfg_we, i_cfg_index, i_cfg_data         i_cfg_we
//
// A sample runs through the program steps from its transfer to its result in the output register, and
// the next input transfer can follow only once the program is back at its idle step:
// seven products share a single registered 32x24 multiplier, one issued per program step.
// Reset (synchronous, active low) loads the coefficient reset values and zeroes all delays.
// The input stalls while a sample is in flight; a finished result waits in the output
// register, and the program holds at its write-back step while that register is full and the output stalls.
module biquad_lowpass_df2t (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bqd_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bqd_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bqd_pkg::COEF_W-1:0]     i_cfg_data
);
    import bqd_pkg::*;

    // Sequencer
    logic [STEP_W-1:0] r_step, n_step;
    t_uop              w_uop;
    logic              w_branch, w_finish, w_in_xfer, w_out_busy;

    // Configuration and channel state
    logic signed [COEF_W-1:0] r_coef [NUM_COEF];
    logic signed [DLY_W-1:0]  r_dly1 [CHANNELS];
    logic signed [DLY_W-1:0]  r_dly2 [CHANNELS];

    // Latched sample
    logic [CHAN_W-1:0]             r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_clr, r_skip;

    // Datapath
    logic signed [COEF_W-1:0]      w_mul_a;
    logic signed [MUL_B_W-1:0]     w_mul_b;
    logic signed [PROD_W-1:0]      r_prod, r_hold;
    logic signed [TERM_W-1:0]      w_term;
    logic signed [MY_W-1:0]        w_mix_term;
    logic signed [DLY_W-1:0]       w_d1, w_d2;
    logic [CH_IDX_W-1:0]           w_ch_idx;
    logic signed [YACC_W-1:0]      r_yacc;
    logic signed [RSUM_W-1:0]      w_rnd_sum;
    logic signed [RND_W-1:0]       w_yr;
    logic signed [YFB_W-1:0]       r_yfb;
    logic signed [MIX_W-1:0]       r_my;
    logic signed [ACC_W-1:0]       r_acc1, r_acc2;
    logic signed [SAMPLE_BITS-1:0] r_ys;
    logic                          r_sat;

    // Result register
    logic      r_out_valid;
    t_out_item r_out;

    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
        logic signed [DLY_W-1:0] r;
        if (v > ACC_W'(DLY_MAX)) begin
            r = DLY_MAX;
        end else if (v < ACC_W'(DLY_MIN)) begin
            r = DLY_MIN;
        end else begin
            r = DLY_W'(v);
        end
        return r;
    endfunction

    assign w_uop      = uop_rom(r_step);
    assign o_in_stall = (r_step != STEP_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_busy = r_out_valid && i_out_stall;

    always_comb begin
        case (w_uop.cond)
            C_NEVER:    w_branch = 1'b0;
            C_ALWAYS:   w_branch = 1'b1;
            C_NO_INPUT: w_branch = !w_in_xfer;
            C_SKIP:     w_branch = r_skip;
            C_OUT_BUSY: w_branch = w_out_busy;
            default:    w_branch = 1'b0;
        endcase
    end

    assign w_finish = w_uop.done && !w_branch;

    always_comb begin
        if (w_branch) begin
            n_step = w_uop.target;
        end else if (w_uop.done) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    // Operand selection
    assign w_mul_a = r_coef[w_uop.mul_a];

    always_comb begin
        case (w_uop.mul_b)
            MB_X:    w_mul_b = r_x;
            MB_YH:   w_mul_b = r_yfb[YFB_W-1:DLY_FRAC];
            MB_YL:   w_mul_b = signed'({{(MUL_B_W-DLY_FRAC){1'b0}}, r_yfb[DLY_FRAC-1:0]});
            default: w_mul_b = r_x;
        endcase
    end

    assign w_ch_idx   = CH_IDX_W'(r_ch);
    assign w_d1       = r_clr ? '0 : r_dly1[w_ch_idx];
    assign w_d2       = r_clr ? '0 : r_dly2[w_ch_idx];
    assign w_term     = TERM_W'(r_prod >>> PROD_SHIFT);
    assign w_mix_term = MY_W'(r_my >>> PROD_SHIFT);
    assign w_rnd_sum  = RSUM_W'(r_yacc) + RND_HALF;
    assign w_yr       = RND_W'(w_rnd_sum >>> DLY_FRAC);

    // Datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        r_hold <= r_prod;
        if (w_in_xfer) begin
            r_ch   <= i_in_data.channel;
            r_x    <= i_in_data.sample_in;
            r_clr  <= i_in_data.clear_state;
            r_skip <= (int'(i_in_data.channel) >= CHANNELS);
        end
        case (w_uop.alu)
            OP_YACC: begin
                r_yacc <= YACC_W'(w_term) + YACC_W'(w_d1);
            end
            OP_D1X: begin
                r_acc1 <= ACC_W'(w_term) + ACC_W'(w_d2);
                // clamp the fed-back y to the sample range, keep its fraction
                if (r_yacc > YACC_W'(YFB_MAX)) begin
                    r_yfb <= YFB_MAX;
                end else if (r_yacc < YACC_W'(YFB_MIN)) begin
                    r_yfb <= YFB_MIN;
                end else begin
                    r_yfb <= YFB_W'(r_yacc);
                end
                if (w_yr > RND_W'(SAMPLE_MAX)) begin
                    r_ys  <= SAMPLE_MAX;
                    r_sat <= 1'b1;
                end else if (w_yr < RND_W'(SAMPLE_MIN)) begin
                    r_ys  <= SAMPLE_MIN;
                    r_sat <= 1'b1;
                end else begin
                    r_ys  <= SAMPLE_BITS'(w_yr);
                    r_sat <= 1'b0;
                end
            end
            OP_D2X: begin
                r_acc2 <= ACC_W'(w_term);
            end
            OP_MIX: begin
                // coef * y = coef * y_high + floor(coef * y_low / 2^frac)
                r_my <= MIX_W'(r_hold) + MIX_W'(r_prod >>> DLY_FRAC);
            end
            OP_SUB1: begin
                r_acc1 <= r_acc1 - ACC_W'(w_mix_term);
            end
            OP_SUB2: begin
                r_acc2 <= r_acc2 - ACC_W'(w_mix_term);
            end
            default: begin
            end
        endcase
        if (w_finish) begin
            r_out.channel_out <= r_ch;
            r_out.sample_out  <= r_skip ? '0 : r_ys;
            r_out.saturated   <= r_skip ? 1'b0 : r_sat;
        end
    end

    // Control, configuration and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= STEP_IDLE;
            r_out_valid    <= 1'b0;
            r_coef[REG_B0] <= COEF_ONE;
            r_coef[REG_B1] <= '0;
            r_coef[REG_B2] <= '0;
            r_coef[REG_A1] <= '0;
            r_coef[REG_A2] <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_dly1[i] <= '0;
                r_dly2[i] <= '0;
            end
        end else begin
            r_step <= n_step;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (int'(i_cfg_index) < NUM_COEF)) begin
                r_coef[i_cfg_index] <= signed'(i_cfg_data);
            end
            // write back both delays; out-of-range channels leave state alone
            if (w_finish && !r_skip) begin
                r_dly1[w_ch_idx] <= sat_dly(r_acc1);
                r_dly2[w_ch_idx] <= sat_dly(r_acc2);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
